@@ hw/rtl/rvx_pkg.sv @@
// shared types and constants of the rv32i instruction executor
package rvx_pkg;

	localparam int unsigned MEM_BYTES_DEF = 4096;

	typedef enum logic [1:0] {
		FAULT_NONE    = 2'd0,
		FAULT_ILLEGAL = 2'd1,
		FAULT_RANGE   = 2'd2
	} fault_t;

	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_HALF = 2'd1,
		SZ_WORD = 2'd2
	} mem_size_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        rd_wr;
		logic [31:0] rd_val;
		logic        mem_rd;
		logic        mem_wr;
		mem_size_t   mem_size;
		logic        mem_unsigned;
		logic [31:0] mem_addr;
		fault_t      fault;
	} ex_t;

endpackage

@@ hw/rtl/rv32i_instruction_executor.sv @@
// rv32i executor top level: pc, register file, banked data memory, two-stage pipeline
// one beat per cycle through both stages while out_ready is high and memory clear is done
// stage one decodes and executes with forwarding from stage two, stage two returns load data
// loads, stores and preloads use one access of four byte banks
// reset clears pc and register valid bits at once, then the data memory is cleared
// one row a cycle over all (MEM_BYTES+3)/4 rows, during which in_ready stays low
module rv32i_instruction_executor #(
	parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] instr_word,
	input  logic [11:0] load_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] executed_pc,
	output logic [31:0] next_pc,
	output logic        rd_written,
	output logic [4:0]  rd_index,
	output logic [31:0] rd_value,
	output logic        mem_written,
	output logic [31:0] mem_address,
	output logic [1:0]  fault
);

	localparam int unsigned ROWS = (MEM_BYTES + 3) / 4;
	localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned AW   = $clog2(MEM_BYTES);
	localparam logic        KIND_PRELOAD = 1'b1;
	localparam logic [31:0] LIM_W = 32'(MEM_BYTES - 4);

	logic        valid_s1, valid_s2;
	logic        in_fire, adv, move;
	logic [31:0] pc_q;
	logic        clr_busy_q;
	logic [RW-1:0] clr_row_q;

	logic        kind_s1;
	logic [31:0] instr_s1;
	logic [11:0] laddr_s1;
	logic [31:0] rs1_raw_s1, rs2_raw_s1;
	logic        rs1_ok_s1, rs2_ok_s1;

	logic [31:0] rf_mem [32];
	logic [31:0] rf_valid_q;
	logic        rf_we, hit1, hit2;
	logic [4:0]  in_rs1, in_rs2, rs1_idx, rs2_idx;
	logic [31:0] rs1_val, rs2_val;

	rvx_pkg::ex_t ex;

	logic        preload, pl_ok, acc_we, acc_re;
	logic [31:0] pl_addr, acc_addr, acc_wdata;
	rvx_pkg::mem_size_t acc_size;
	logic [1:0]  lane_max;
	logic [1:0]  lane [4];
	logic [RW-1:0] row [4];
	logic [3:0]  ben;
	logic [7:0]  dmem [4][ROWS];

	logic [31:0] executed_pc_s2, next_pc_s2, alu_val_s2, mem_address_s2;
	logic        rd_written_s2, mem_written_s2, ld_s2, ld_uns_s2;
	logic [4:0]  rd_index_s2;
	rvx_pkg::fault_t fault_s2;
	rvx_pkg::mem_size_t ld_size_s2;
	logic [1:0]  ld_off_s2;
	logic [7:0]  bank_rd_s2 [4];
	logic [31:0] ld_raw, ld_val, rd_value_c;

	assign adv      = !valid_s2 || out_ready;
	assign move     = valid_s1 && adv;
	assign in_ready = !clr_busy_q && (!valid_s1 || adv);
	assign in_fire  = in_valid && in_ready;

	// register file, written when a result beat leaves
	assign rf_we   = valid_s2 && out_ready && rd_written_s2;
	assign in_rs1  = instr_word[19:15];
	assign in_rs2  = instr_word[24:20];
	assign hit1    = rf_we && (rd_index_s2 == in_rs1);
	assign hit2    = rf_we && (rd_index_s2 == in_rs2);

	always_ff @(posedge clk) begin
		if (rf_we)
			rf_mem[rd_index_s2] <= rd_value_c;
		if (in_fire) begin
			rs1_raw_s1 <= hit1 ? rd_value_c : rf_mem[in_rs1];
			rs2_raw_s1 <= hit2 ? rd_value_c : rf_mem[in_rs2];
			rs1_ok_s1  <= hit1 || rf_valid_q[in_rs1];
			rs2_ok_s1  <= hit2 || rf_valid_q[in_rs2];
			kind_s1    <= opcode;
			instr_s1   <= instr_word;
			laddr_s1   <= load_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
		end else if (rf_we) begin
			rf_valid_q[rd_index_s2] <= 1'b1;
		end
	end

	assign rs1_idx = instr_s1[19:15];
	assign rs2_idx = instr_s1[24:20];

	always_comb begin
		if (valid_s2 && rd_written_s2 && rd_index_s2 == rs1_idx)
			rs1_val = rd_value_c;
		else
			rs1_val = rs1_ok_s1 ? rs1_raw_s1 : '0;
		if (valid_s2 && rd_written_s2 && rd_index_s2 == rs2_idx)
			rs2_val = rd_value_c;
		else
			rs2_val = rs2_ok_s1 ? rs2_raw_s1 : '0;
	end

	rvx_exec #(
		.MEM_BYTES(MEM_BYTES)
	) u_exec (
		.instr  (instr_s1),
		.pc     (pc_q),
		.rs1_val(rs1_val),
		.rs2_val(rs2_val),
		.res    (ex)
	);

	// data memory access
	assign preload   = (kind_s1 == KIND_PRELOAD);
	assign pl_addr   = {20'd0, laddr_s1};
	assign pl_ok     = pl_addr <= LIM_W;
	assign acc_addr  = preload ? pl_addr : ex.mem_addr;
	assign acc_size  = preload ? rvx_pkg::SZ_WORD : ex.mem_size;
	assign acc_wdata = preload ? instr_s1 : rs2_val;
	assign acc_we    = preload ? pl_ok : ex.mem_wr;
	assign acc_re    = !preload && ex.mem_rd;

	always_comb begin
		unique case (acc_size)
			rvx_pkg::SZ_BYTE: lane_max = 2'd0;
			rvx_pkg::SZ_HALF: lane_max = 2'd1;
			default:          lane_max = 2'd3;
		endcase
	end

	always_comb begin
		logic [AW:0] bsum;
		for (int k = 0; k < 4; k++) begin
			lane[k] = 2'(k) - acc_addr[1:0];
			bsum    = {1'b0, acc_addr[AW-1:0]} + (AW+1)'(lane[k]);
			row[k]  = bsum[RW+1:2];
			ben[k]  = lane[k] <= lane_max;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (clr_busy_q)
				dmem[k][clr_row_q] <= '0;
			else if (move && acc_we && ben[k])
				dmem[k][row[k]] <= acc_wdata[{lane[k], 3'b000} +: 8];
			if (move && acc_re && ben[k])
				bank_rd_s2[k] <= dmem[k][row[k]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_row_q == RW'(ROWS - 1))
				clr_busy_q <= 1'b0;
			else
				clr_row_q <= clr_row_q + 1'b1;
		end
	end

	// pipeline control and pc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pc_q     <= '0;
		end else begin
			if (in_fire)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= valid_s1;
			if (move && !preload)
				pc_q <= ex.next_pc;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			executed_pc_s2 <= pc_q;
			next_pc_s2     <= preload ? pc_q : ex.next_pc;
			rd_written_s2  <= !preload && ex.rd_wr;
			rd_index_s2    <= (!preload && ex.rd_wr) ? instr_s1[11:7] : 5'd0;
			alu_val_s2     <= ex.rd_val;
			mem_written_s2 <= acc_we;
			mem_address_s2 <= acc_addr;
			if (preload)
				fault_s2 <= pl_ok ? rvx_pkg::FAULT_NONE : rvx_pkg::FAULT_RANGE;
			else
				fault_s2 <= ex.fault;
			ld_s2      <= acc_re;
			ld_off_s2  <= acc_addr[1:0];
			ld_size_s2 <= ex.mem_size;
			ld_uns_s2  <= ex.mem_unsigned;
		end
	end

	// load data return
	always_comb begin
		logic [1:0] bi;
		for (int i = 0; i < 4; i++) begin
			bi = ld_off_s2 + 2'(i);
			ld_raw[8*i +: 8] = bank_rd_s2[bi];
		end
	end

	always_comb begin
		unique case (ld_size_s2)
			rvx_pkg::SZ_BYTE: ld_val = {{24{!ld_uns_s2 && ld_raw[7]}}, ld_raw[7:0]};
			rvx_pkg::SZ_HALF: ld_val = {{16{!ld_uns_s2 && ld_raw[15]}}, ld_raw[15:0]};
			default:          ld_val = ld_raw;
		endcase
	end

	assign rd_value_c = !rd_written_s2 ? '0 : (ld_s2 ? ld_val : alu_val_s2);

	assign out_valid   = valid_s2;
	assign executed_pc = executed_pc_s2;
	assign next_pc     = next_pc_s2;
	assign rd_written  = rd_written_s2;
	assign rd_index    = rd_index_s2;
	assign rd_value    = rd_value_c;
	assign mem_written = mem_written_s2;
	assign mem_address = mem_address_s2;
	assign fault       = fault_s2;

	a_pc_follows: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> (pc_q == next_pc_s2))
		else $error("pc does not match next_pc of the beat just executed");

	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> (rd_index_s2 != 5'd0))
		else $error("register x0 written");

	a_illegal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && fault_s2 == rvx_pkg::FAULT_ILLEGAL) |->
		(!rd_written_s2 && !mem_written_s2 && next_pc_s2 == executed_pc_s2 + 32'd4))
		else $error("unsupported instruction changed state");

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!valid_s1 && !valid_s2))
		else $error("item in flight during memory clear");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && fault_s2 == rvx_pkg::FAULT_RANGE) |-> (rd_value == 32'd0 && !mem_written))
		else $error("out of range access returned data or wrote memory");

endmodule

@@ hw/rtl/rvx_exec.sv @@
// decode, alu, branch and address generation for one instruction
module rvx_exec #(
	parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
	input  logic [31:0]  instr,
	input  logic [31:0]  pc,
	input  logic [31:0]  rs1_val,
	input  logic [31:0]  rs2_val,
	output rvx_pkg::ex_t res
);

	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_FENCE  = 7'h0F;
	localparam logic [6:0] OP_ALUI   = 7'h13;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_ALUR   = 7'h33;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_MASK   = 7'h7F;

	localparam logic [31:0] IMM_U_MASK = 32'hFFFFF000;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LW   = 3'd2;
	localparam logic [2:0] F3_LWU  = 3'd6;
	localparam logic [2:0] F3_LDU  = 3'd7;
	localparam logic [2:0] F3_LD   = 3'd3;
	localparam logic [2:0] F3_SW   = 3'd2;
	localparam logic [2:0] F3_JALR = 3'd0;
	localparam logic [2:0] F3_FENCEI = 3'd1;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [31:0] LIM_B = 32'(MEM_BYTES - 1);
	localparam logic [31:0] LIM_H = 32'(MEM_BYTES - 2);
	localparam logic [31:0] LIM_W = 32'(MEM_BYTES - 4);

	logic [6:0]  op;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
	logic [31:0] pc4, opb, alu, agen_i, agen_s, lim, jalr_sum;
	logic [4:0]  sh;
	logic        lt_s, lt_u, taken, illegal, alu_ok;
	logic        wr, mrd, mwr;
	logic [31:0] val, npc, maddr;
	rvx_pkg::fault_t flt;

	assign op     = instr[6:0] & OP_MASK;
	assign rd     = instr[11:7];
	assign f3     = instr[14:12];
	assign f7     = instr[31:25];
	assign imm_i  = {{20{instr[31]}}, instr[31:20]};
	assign imm_s  = {{20{instr[31]}}, instr[31:25], instr[11:7]};
	assign imm_b  = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
	assign imm_j  = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
	assign imm_u  = instr & IMM_U_MASK;
	assign pc4    = pc + 32'd4;
	assign opb    = (op == OP_ALUI) ? imm_i : rs2_val;
	assign sh     = opb[4:0];
	assign lt_s   = $signed(rs1_val) < $signed(opb);
	assign lt_u   = rs1_val < opb;
	assign agen_i = rs1_val + imm_i;
	assign agen_s = rs1_val + imm_s;
	assign jalr_sum = rs1_val + imm_i;

	always_comb begin
		unique case (f3[1:0])
			2'd0:    lim = LIM_B;
			2'd1:    lim = LIM_H;
			default: lim = LIM_W;
		endcase
	end

	always_comb begin
		unique case (f3)
			F3_ADD:  alu = (op == OP_ALUR && f7 == F7_ALT) ? rs1_val - opb : rs1_val + opb;
			F3_SLL:  alu = rs1_val << sh;
			F3_SLT:  alu = {31'd0, lt_s};
			F3_SLTU: alu = {31'd0, lt_u};
			F3_XOR:  alu = rs1_val ^ opb;
			F3_SR:   alu = (f7 == F7_ALT) ? 32'($signed(rs1_val) >>> sh) : rs1_val >> sh;
			F3_OR:   alu = rs1_val | opb;
			F3_AND:  alu = rs1_val & opb;
			default: alu = '0;
		endcase
	end

	always_comb begin
		if (op == OP_ALUI) begin
			if (f3 == F3_SLL)
				alu_ok = (f7 == F7_BASE);
			else if (f3 == F3_SR)
				alu_ok = (f7 == F7_BASE) || (f7 == F7_ALT);
			else
				alu_ok = 1'b1;
		end else begin
			alu_ok = (f7 == F7_BASE) || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR));
		end
	end

	always_comb begin
		unique case (f3)
			F3_BEQ:  taken = rs1_val == rs2_val;
			F3_BNE:  taken = rs1_val != rs2_val;
			F3_BLT:  taken = lt_s;
			F3_BGE:  taken = !lt_s;
			F3_BLTU: taken = lt_u;
			F3_BGEU: taken = !lt_u;
			default: taken = 1'b0;
		endcase
	end

	always_comb begin
		illegal = 1'b0;
		wr      = 1'b0;
		val     = '0;
		npc     = pc4;
		mrd     = 1'b0;
		mwr     = 1'b0;
		maddr   = '0;
		flt     = rvx_pkg::FAULT_NONE;
		unique case (op)
			OP_LUI: begin
				wr  = 1'b1;
				val = imm_u;
			end
			OP_AUIPC: begin
				wr  = 1'b1;
				val = pc + imm_u;
			end
			OP_JAL: begin
				wr  = 1'b1;
				val = pc4;
				npc = pc + imm_j;
			end
			OP_JALR: begin
				if (f3 != F3_JALR) begin
					illegal = 1'b1;
				end else begin
					wr  = 1'b1;
					val = pc4;
					npc = {jalr_sum[31:1], 1'b0};
				end
			end
			OP_BRANCH: begin
				if (f3 == F3_SLT || f3 == F3_SLTU)
					illegal = 1'b1;
				else if (taken)
					npc = pc + imm_b;
			end
			OP_LOAD: begin
				if (f3 == F3_LD || f3 == F3_LWU || f3 == F3_LDU) begin
					illegal = 1'b1;
				end else begin
					wr    = 1'b1;
					maddr = agen_i;
					if (agen_i <= lim)
						mrd = 1'b1;
					else
						flt = rvx_pkg::FAULT_RANGE;
				end
			end
			OP_STORE: begin
				if (f3 > F3_SW) begin
					illegal = 1'b1;
				end else begin
					maddr = agen_s;
					if (agen_s <= lim)
						mwr = 1'b1;
					else
						flt = rvx_pkg::FAULT_RANGE;
				end
			end
			OP_ALUI, OP_ALUR: begin
				if (!alu_ok) begin
					illegal = 1'b1;
				end else begin
					wr  = 1'b1;
					val = alu;
				end
			end
			OP_FENCE: begin
				if (f3 > F3_FENCEI)
					illegal = 1'b1;
			end
			default: illegal = 1'b1;
		endcase
		if (illegal) begin
			wr    = 1'b0;
			val   = '0;
			npc   = pc4;
			mrd   = 1'b0;
			mwr   = 1'b0;
			maddr = '0;
			flt   = rvx_pkg::FAULT_ILLEGAL;
		end
		if (rd == 5'd0) begin
			wr  = 1'b0;
			val = '0;
		end
	end

	always_comb begin
		res.next_pc      = npc;
		res.rd_wr        = wr;
		res.rd_val       = val;
		res.mem_rd       = mrd;
		res.mem_wr       = mwr;
		res.mem_size     = rvx_pkg::mem_size_t'(f3[1:0]);
		res.mem_unsigned = f3[2];
		res.mem_addr     = maddr;
		res.fault        = flt;
	end

endmodule

@@ bench/rv32i_retire_checker.sv @@
// bench encodings and the result checker with its own executor model
package rvx_tb_pkg;

	localparam logic ITEM_EXEC    = 1'b0;
	localparam logic ITEM_PRELOAD = 1'b1;

	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_FENCE  = 7'h0F;
	localparam logic [6:0] OPC_ALUI   = 7'h13;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_ALUR   = 7'h33;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	localparam logic [2:0] F3_SB = 3'd0;
	localparam logic [2:0] F3_SH = 3'd1;
	localparam logic [2:0] F3_SW = 3'd2;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_JALR   = 3'd0;
	localparam logic [2:0] F3_FENCE  = 3'd0;
	localparam logic [2:0] F3_FENCEI = 3'd1;
	localparam logic [2:0] F3_CSRRS  = 3'd2;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [31:0] INSTR_ECALL  = 32'h0000_0073;
	localparam logic [31:0] INSTR_EBREAK = 32'h0010_0073;

endpackage

module rv32i_retire_checker #(
	parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] instr_word,
	input  logic [11:0] load_address,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] executed_pc,
	input  logic [31:0] next_pc,
	input  logic        rd_written,
	input  logic [4:0]  rd_index,
	input  logic [31:0] rd_value,
	input  logic        mem_written,
	input  logic [31:0] mem_address,
	input  logic [1:0]  fault,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import rvx_pkg::*;
	import rvx_tb_pkg::*;

	typedef struct packed {
		logic [31:0] exec_pc;
		logic [31:0] fetch_pc;
		logic        rd_wr;
		logic [4:0]  rd_idx;
		logic [31:0] rd_val;
		logic        mem_wr;
		logic [31:0] mem_addr;
		fault_t      flt;
	} retire_t;

	logic [31:0] arch_pc;
	logic [31:0] arch_regs [32];
	logic [7:0]  data_mem [MEM_BYTES];
	retire_t     retire_q [$];
	retire_t     want;
	int unsigned errs = 0;
	int unsigned queued = 0;

	assign mismatches  = errs;
	assign outstanding = queued;

	function automatic logic fits(input logic [31:0] addr, input int unsigned nbytes);
		return addr <= MEM_BYTES - nbytes;
	endfunction

	function automatic void mem_store(input logic [31:0] addr, input int unsigned nbytes,
			input logic [31:0] data);
		int i;
		for (i = 0; i < nbytes; i++)
			data_mem[addr + i] = data[8*i +: 8];
	endfunction

	function automatic retire_t retire_item(input logic kind, input logic [31:0] w,
			input logic [11:0] laddr);
		retire_t     r;
		logic [31:0] a, b, val, immi, imms, immb, immj;
		logic [6:0]  f7;
		logic [2:0]  f3;
		logic [4:0]  rd, sh;
		logic        wr, illegal, taken;
		int unsigned nbytes;
		int          i;
		a = arch_regs[w[19:15]];
		b = arch_regs[w[24:20]];
		rd = w[11:7];
		f3 = w[14:12];
		f7 = w[31:25];
		immi = {{20{w[31]}}, w[31:20]};
		imms = {{20{w[31]}}, w[31:25], w[11:7]};
		immb = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
		immj = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
		r = '0;
		r.exec_pc = arch_pc;
		r.fetch_pc = arch_pc + 32'd4;
		r.flt = FAULT_NONE;
		wr = 1'b0;
		val = '0;
		illegal = 1'b0;
		taken = 1'b0;
		nbytes = 4;

		if (kind == ITEM_PRELOAD) begin
			r.fetch_pc = arch_pc;
			r.mem_addr = {20'd0, laddr};
			if (fits(r.mem_addr, 4)) begin
				mem_store(r.mem_addr, 4, w);
				r.mem_wr = 1'b1;
			end else
				r.flt = FAULT_RANGE;
			return r;
		end

		case (w[6:0])
		OPC_LUI: begin
			wr = 1'b1;
			val = {w[31:12], 12'd0};
		end
		OPC_AUIPC: begin
			wr = 1'b1;
			val = arch_pc + {w[31:12], 12'd0};
		end
		OPC_JAL: begin
			wr = 1'b1;
			val = arch_pc + 32'd4;
			r.fetch_pc = arch_pc + immj;
		end
		OPC_JALR: begin
			if (f3 != F3_JALR)
				illegal = 1'b1;
			else begin
				wr = 1'b1;
				val = arch_pc + 32'd4;
				r.fetch_pc = (a + immi) & ~32'd1;
			end
		end
		OPC_BRANCH: begin
			case (f3)
			F3_BEQ:  taken = a == b;
			F3_BNE:  taken = a != b;
			F3_BLT:  taken = $signed(a) < $signed(b);
			F3_BGE:  taken = $signed(a) >= $signed(b);
			F3_BLTU: taken = a < b;
			F3_BGEU: taken = a >= b;
			default: illegal = 1'b1;
			endcase
			if (taken)
				r.fetch_pc = arch_pc + immb;
		end
		OPC_LOAD: begin
			case (f3)
			F3_LB, F3_LBU: nbytes = 1;
			F3_LH, F3_LHU: nbytes = 2;
			F3_LW:         nbytes = 4;
			default:       illegal = 1'b1;
			endcase
			if (!illegal) begin
				r.mem_addr = a + immi;
				wr = 1'b1;
				if (!fits(r.mem_addr, nbytes))
					r.flt = FAULT_RANGE;
				else begin
					for (i = 0; i < nbytes; i++)
						val[8*i +: 8] = data_mem[r.mem_addr + i];
					if (f3 == F3_LB)
						val = {{24{val[7]}}, val[7:0]};
					else if (f3 == F3_LH)
						val = {{16{val[15]}}, val[15:0]};
				end
			end
		end
		OPC_STORE: begin
			case (f3)
			F3_SB:   nbytes = 1;
			F3_SH:   nbytes = 2;
			F3_SW:   nbytes = 4;
			default: illegal = 1'b1;
			endcase
			if (!illegal) begin
				r.mem_addr = a + imms;
				if (fits(r.mem_addr, nbytes)) begin
					mem_store(r.mem_addr, nbytes, b);
					r.mem_wr = 1'b1;
				end else
					r.flt = FAULT_RANGE;
			end
		end
		OPC_ALUI: begin
			wr = 1'b1;
			sh = w[24:20];
			case (f3)
			F3_ADD:  val = a + immi;
			F3_SLT:  val = {31'd0, $signed(a) < $signed(immi)};
			F3_SLTU: val = {31'd0, a < immi};
			F3_XOR:  val = a ^ immi;
			F3_OR:   val = a | immi;
			F3_AND:  val = a & immi;
			F3_SLL: begin
				if (f7 != F7_BASE)
					illegal = 1'b1;
				else
					val = a << sh;
			end
			default: begin
				if (f7 == F7_BASE)
					val = a >> sh;
				else if (f7 == F7_ALT)
					val = $signed(a) >>> sh;
				else
					illegal = 1'b1;
			end
			endcase
		end
		OPC_ALUR: begin
			wr = 1'b1;
			sh = b[4:0];
			if (f7 == F7_ALT && f3 == F3_ADD)
				val = a - b;
			else if (f7 == F7_ALT && f3 == F3_SR)
				val = $signed(a) >>> sh;
			else if (f7 != F7_BASE)
				illegal = 1'b1;
			else begin
				case (f3)
				F3_ADD:  val = a + b;
				F3_SLL:  val = a << sh;
				F3_SLT:  val = {31'd0, $signed(a) < $signed(b)};
				F3_SLTU: val = {31'd0, a < b};
				F3_XOR:  val = a ^ b;
				F3_SR:   val = a >> sh;
				F3_OR:   val = a | b;
				default: val = a & b;
				endcase
			end
		end
		OPC_FENCE: begin
			if (f3 != F3_FENCE && f3 != F3_FENCEI)
				illegal = 1'b1;
		end
		default: illegal = 1'b1;
		endcase

		if (illegal) begin
			wr = 1'b0;
			r.fetch_pc = arch_pc + 32'd4;
			r.mem_addr = '0;
			r.mem_wr = 1'b0;
			r.flt = FAULT_ILLEGAL;
		end
		if (rd == 5'd0)
			wr = 1'b0;
		if (wr) begin
			arch_regs[rd] = val;
			r.rd_wr = 1'b1;
			r.rd_idx = rd;
			r.rd_val = val;
		end
		arch_pc = r.fetch_pc;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, actual %0h", name, exp_val, act_val);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_pc = '0;
			foreach (arch_regs[i])
				arch_regs[i] = '0;
			foreach (data_mem[i])
				data_mem[i] = '0;
			retire_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (retire_q.size() == 0) begin
					$error("result beat with nothing expected, executed_pc %0h", executed_pc);
					errs++;
				end else begin
					want = retire_q.pop_front();
					check_field("executed_pc", want.exec_pc, executed_pc);
					check_field("next_pc", want.fetch_pc, next_pc);
					check_field("rd_written", want.rd_wr, rd_written);
					check_field("rd_index", want.rd_idx, rd_index);
					check_field("rd_value", want.rd_val, rd_value);
					check_field("mem_written", want.mem_wr, mem_written);
					check_field("mem_address", want.mem_addr, mem_address);
					check_field("fault", want.flt, fault);
				end
			end
			if (in_valid && in_ready)
				retire_q.push_back(retire_item(opcode, instr_word, load_address));
		end
		queued = retire_q.size();
	end

endmodule

@@ bench/tb_rv32i_instruction_executor.sv @@
// top of the executor testbench: clock, reset, instruction stimulus and verdict
module tb_rv32i_instruction_executor;
	timeunit 1ns;
	timeprecision 1ps;

	import rvx_tb_pkg::*;

	localparam int unsigned MEM_SIZE       = rvx_pkg::MEM_BYTES_DEF;
	localparam int unsigned ITEM_TARGET    = 1700;
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	localparam logic [2:0] LOAD_F3S [5]   = '{F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU};
	localparam logic [2:0] STORE_F3S [3]  = '{F3_SB, F3_SH, F3_SW};
	localparam logic [2:0] BRANCH_F3S [6] = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [31:0] instr_word;
	logic [11:0] load_address;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] executed_pc;
	logic [31:0] next_pc;
	logic        rd_written;
	logic [4:0]  rd_index;
	logic [31:0] rd_value;
	logic        mem_written;
	logic [31:0] mem_address;
	logic [1:0]  fault;
	int unsigned mismatches;
	int unsigned outstanding;

	int unsigned burst_left = 0;
	int unsigned beats_sent = 0;
	int unsigned idle_cycles = 0;

	rv32i_instruction_executor DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.instr_word   (instr_word),
		.load_address (load_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.executed_pc  (executed_pc),
		.next_pc      (next_pc),
		.rd_written   (rd_written),
		.rd_index     (rd_index),
		.rd_value     (rd_value),
		.mem_written  (mem_written),
		.mem_address  (mem_address),
		.fault        (fault)
	);

	rv32i_retire_checker u_retire_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.instr_word   (instr_word),
		.load_address (load_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.executed_pc  (executed_pc),
		.next_pc      (next_pc),
		.rd_written   (rd_written),
		.rd_index     (rd_index),
		.rd_value     (rd_value),
		.mem_written  (mem_written),
		.mem_address  (mem_address),
		.fault        (fault),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OPC_ALUR};
	endfunction

	function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
			input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
	endfunction

	function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
			input logic [4:0] rs1, input logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
	endfunction

	function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
			input logic [6:0] opc);
		return {imm, rd, opc};
	endfunction

	function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
	endfunction

	function automatic logic [31:0] corner_value();
		case ($urandom_range(0, 6))
		0: return 32'd0;
		1: return 32'd1;
		2: return 32'h7FFF_FFFF;
		3: return 32'h8000_0000;
		4: return 32'hFFFF_FFFF;
		5: return $urandom_range(0, 31);
		default: return $urandom;
		endcase
	endfunction

	task automatic drive_beat(input logic kind, input logic [31:0] word,
			input logic [11:0] addr);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= kind;
		instr_word <= word;
		load_address <= addr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		beats_sent++;
	endtask

	task automatic run_instr(input logic [31:0] word);
		drive_beat(ITEM_EXEC, word, 12'($urandom));
	endtask

	task automatic preload_word(input logic [11:0] addr, input logic [31:0] word);
		drive_beat(ITEM_PRELOAD, word, addr);
	endtask

	// lui then addi, low part taken as signed
	task automatic load_const(input logic [4:0] rd, input logic [31:0] value);
		logic [31:0] hi;
		hi = (value + 32'h800) >> 12;
		run_instr(enc_u(hi[19:0], rd, OPC_LUI));
		run_instr(enc_i(value[11:0], rd, F3_ADD, rd, OPC_ALUI));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int unsigned mode, span;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(32, 256);
			repeat (span) begin
				@(negedge clk);
				case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] target, base, word;
		logic [11:0] off, off2, imm;
		logic [4:0]  rb, rs1, rs2, rd;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic        is_reg;
		int unsigned pick, sel, n;

		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = ITEM_EXEC;
		instr_word = '0;
		load_address = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// preloads at both ends of memory, one past the last full word
		preload_word(12'd0, 32'hDEAD_BEEF);
		preload_word(12'(MEM_SIZE - 4), 32'h80FF_7F01);
		preload_word(12'(MEM_SIZE - 3), 32'h1234_5678);
		load_const(5'd1, MEM_SIZE - 4);
		// load and store widths, sign extension, unaligned and out of range
		run_instr(enc_i(12'd0, 5'd1, F3_LW, 5'd2, OPC_LOAD));
		run_instr(enc_i(12'd3, 5'd1, F3_LB, 5'd3, OPC_LOAD));
		run_instr(enc_i(12'd2, 5'd1, F3_LHU, 5'd4, OPC_LOAD));
		run_instr(enc_i(12'd1, 5'd1, F3_LH, 5'd5, OPC_LOAD));
		run_instr(enc_i(12'd1, 5'd1, F3_LW, 5'd6, OPC_LOAD));
		run_instr(enc_s(12'd3, 5'd2, 5'd1, F3_SH));
		run_instr(enc_s(12'd3, 5'd2, 5'd1, F3_SB));
		// compares, shift masking, sub
		run_instr(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd7, OPC_ALUI));
		run_instr(enc_r(F7_ALT, 5'd7, 5'd7, F3_SR, 5'd8));
		run_instr(enc_r(F7_BASE, 5'd7, 5'd7, F3_SR, 5'd9));
		run_instr(enc_r(F7_BASE, 5'd7, 5'd0, F3_SLTU, 5'd10));
		run_instr(enc_i(12'hFFF, 5'd1, F3_SLTU, 5'd11, OPC_ALUI));
		run_instr(enc_i(12'd0, 5'd7, F3_SLT, 5'd12, OPC_ALUI));
		run_instr(enc_r(F7_ALT, 5'd7, 5'd0, F3_ADD, 5'd13));
		// jumps and branches, odd jalr target
		run_instr(enc_i(12'd1, 5'd1, F3_JALR, 5'd14, OPC_JALR));
		run_instr(enc_b(13'h1FF8, 5'd0, 5'd7, F3_BLT));
		run_instr(enc_j(21'h10_0000, 5'd15));
		// fence, system and bad encodings
		run_instr(enc_i(12'd0, 5'd0, F3_FENCEI, 5'd0, OPC_FENCE));
		run_instr(INSTR_ECALL);
		run_instr(enc_i(12'h300, 5'd0, F3_CSRRS, 5'd1, OPC_SYSTEM));
		run_instr(enc_i({F7_ALT, 5'd3}, 5'd1, F3_SLL, 5'd16, OPC_ALUI));

		while (beats_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			rd = $urandom;
			rs1 = $urandom;
			rs2 = $urandom;
			if (pick < 30) begin
				// base register setup then a few accesses around it
				rb = $urandom_range(1, 31);
				sel = $urandom_range(0, 19);
				if (sel < 13)
					target = $urandom_range(0, MEM_SIZE - 1);
				else if (sel < 17)
					target = $urandom_range(MEM_SIZE - 8, MEM_SIZE - 1);
				else if (sel < 19)
					target = $urandom_range(0, 15);
				else
					target = $urandom;
				off = 12'($urandom_range(0, 63)) - 12'd32;
				base = target - {{20{off[11]}}, off};
				load_const(rb, base);
				if ($urandom_range(0, 3) == 0)
					load_const(rs2, corner_value());
				n = $urandom_range(1, 4);
				repeat (n) begin
					off2 = off + 12'($urandom_range(0, 6)) - 12'd3;
					rd = $urandom;
					if (rd == rb)
						rd = rb ^ 5'd1;
					if ($urandom_range(0, 1) == 0) begin
						f3 = ($urandom_range(0, 15) == 0) ? 3'($urandom)
							: STORE_F3S[$urandom_range(0, 2)];
						run_instr(enc_s(off2, rs2, rb, f3));
					end else begin
						f3 = ($urandom_range(0, 15) == 0) ? 3'($urandom)
							: LOAD_F3S[$urandom_range(0, 4)];
						run_instr(enc_i(off2, rb, f3, rd, OPC_LOAD));
					end
				end
			end else if (pick < 55) begin
				if ($urandom_range(0, 3) == 0)
					load_const(rs1, corner_value());
				if ($urandom_range(0, 3) == 0)
					load_const(rs2, corner_value());
				f3 = $urandom;
				is_reg = $urandom_range(0, 1);
				if ($urandom_range(0, 19) == 0)
					f7 = $urandom;
				else if ((f3 == F3_SR || (is_reg && f3 == F3_ADD)) && $urandom_range(0, 1))
					f7 = F7_ALT;
				else
					f7 = F7_BASE;
				if (is_reg)
					run_instr(enc_r(f7, rs2, rs1, f3, rd));
				else begin
					if (f3 == F3_SLL || f3 == F3_SR)
						imm = {f7, 5'($urandom)};
					else if ($urandom_range(0, 2) == 0)
						imm = 12'(corner_value());
					else
						imm = $urandom;
					run_instr(enc_i(imm, rs1, f3, rd, OPC_ALUI));
				end
			end else if (pick < 65) begin
				f3 = ($urandom_range(0, 9) == 0) ? 3'($urandom)
					: BRANCH_F3S[$urandom_range(0, 5)];
				if ($urandom_range(0, 3) == 0)
					rs2 = rs1;
				run_instr(enc_b(13'($urandom), rs2, rs1, f3));
			end else if (pick < 73) begin
				if ($urandom_range(0, 1))
					run_instr(enc_j(21'($urandom), rd));
				else begin
					f3 = ($urandom_range(0, 7) == 0) ? 3'($urandom) : F3_JALR;
					run_instr(enc_i(12'($urandom), rs1, f3, rd, OPC_JALR));
				end
			end else if (pick < 81) begin
				if ($urandom_range(0, 7) == 0)
					preload_word(12'($urandom_range(MEM_SIZE - 8, MEM_SIZE - 1)), $urandom);
				else
					preload_word(12'($urandom), $urandom);
			end else if (pick < 88) begin
				run_instr(enc_u(20'($urandom), rd, $urandom_range(0, 1) ? OPC_LUI : OPC_AUIPC));
			end else if (pick < 93) begin
				word = $urandom;
				case ($urandom_range(0, 4))
				0: word = INSTR_ECALL;
				1: word = INSTR_EBREAK;
				2: word[6:0] = OPC_SYSTEM;
				3: word[6:0] = OPC_FENCE;
				default: word[31:25] = 7'($urandom_range(1, 127)) ^ F7_ALT;
				endcase
				if (word[6:0] == F7_BASE)
					word[6:0] = OPC_ALUR;
				run_instr(word);
			end else begin
				run_instr($urandom);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (10) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ rv32i_instruction_executor.f @@
hw/rtl/rvx_pkg.sv
hw/rtl/rvx_exec.sv
hw/rtl/rv32i_instruction_executor.sv
bench/rv32i_retire_checker.sv
bench/tb_rv32i_instruction_executor.sv
